// File: rtl/anep_pkg.sv
`default_nettype none
package anep_pkg;

  // Default sizes of the node store and the arithmetic.
  localparam int MAX_NODES_DEF  = 64;
  localparam int MAX_DEGREE_DEF = 8;
  localparam int COORD_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 8;

  // Stream widths and the placement of the fields.
  localparam int IN_TDATA_W  = 48;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 40;
  localparam int FIELD_W     = 16;
  localparam int PX_LSB      = 0;
  localparam int PY_LSB      = 16;
  localparam int EXIT_BIT    = 32;
  localparam int FROM_LSB    = 33;
  localparam int TO_LSB      = 39;
  localparam int IDX_IN_W    = 6;
  localparam int STATUS_W    = 3;

  localparam logic [31:0] COST_MAX = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    OP_NODE   = 2'd0,
    OP_EDGE   = 2'd1,
    OP_SEARCH = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_PATH     = 3'd0,
    ST_NO_START = 3'd1,
    ST_NO_EXIT  = 3'd2,
    ST_NO_PATH  = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  // Datapath operations issued by the controller, one per cycle.
  typedef enum logic [4:0] {
    CMD_IDLE,
    CMD_ACCEPT,
    CMD_IDX_CLR,
    CMD_NODE_WR,
    CMD_CNT_RD,
    CMD_EDGE_WR,
    CMD_ERR,
    CMD_FIND_RD,
    CMD_FIND_CHK,
    CMD_INIT,
    CMD_SEL_RD,
    CMD_SEL_CHK,
    CMD_CUR_RD,
    CMD_CUR_LD,
    CMD_NB_RD,
    CMD_NB_CHK,
    CMD_NB_LD,
    CMD_TENT,
    CMD_RELAX,
    CMD_H_RD,
    CMD_H_CHK,
    CMD_H_MIN,
    CMD_F_WR,
    CMD_PATH_RD,
    CMD_PATH_OUT
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t op;
    status_t err;
  } cmd_t;

  typedef struct packed {
    op_t  in_op;
    logic full;
    logic edge_bad;
    logic cnt_full;
    logic idx_end;
    logic find_hit;
    logic any_exit;
    logic best_found;
    logic cur_exit;
    logic k_end;
    logic nb_skip;
    logic dist_done;
    logic relax_skip;
    logic h_exit;
    logic path_last;
    logic out_free;
  } dp_stat_t;

  // Cost addition that sticks at the largest cost.
  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? COST_MAX : s[31:0];
  endfunction

endpackage
`default_nettype wire

// File: rtl/anep_dist.sv
`default_nettype none
module anep_dist #(
  parameter int COORD_BITS = anep_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = anep_pkg::FRAC_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic signed [COORD_BITS-1:0] ax,
  input  wire logic signed [COORD_BITS-1:0] ay,
  input  wire logic signed [COORD_BITS-1:0] bx,
  input  wire logic signed [COORD_BITS-1:0] by,
  output logic                              done,
  output logic [31:0]                       dist_len
);
  import anep_pkg::*;

  localparam int C   = COORD_BITS;
  localparam int SQW = 2 * C + 2;
  localparam int SW  = 2 * C + 3;
  localparam int RB  = C + FRAC_BITS + 2;
  localparam int RW  = 2 * RB;
  localparam int RMW = RB + 3;
  localparam int ITW = $clog2(RB + 1);

  logic signed [C:0] dx, dy;
  logic [C:0]        ux, uy;
  logic [SQW-1:0]    sqx, sqy;
  logic [RW-1:0]     rad;
  logic [RMW-1:0]    rem, rem_sh, trial, rem_next;
  logic [RB-1:0]     root, root_next;
  logic [ITW-1:0]    cnt;
  logic              sq_go, sum_go, run;

  // Signed differences of the two points.
  assign dx = {ax[C-1], ax} - {bx[C-1], bx};
  assign dy = {ay[C-1], ay} - {by[C-1], by};

  // One root bit per cycle, restoring square root.
  always_comb begin
    rem_sh = {rem[RMW-3:0], rad[RW-1:RW-2]};
    trial  = RMW'({root, 2'b01});
    if (rem_sh >= trial) begin
      rem_next  = rem_sh - trial;
      root_next = {root[RB-2:0], 1'b1};
    end else begin
      rem_next  = rem_sh;
      root_next = {root[RB-2:0], 1'b0};
    end
  end

  // Sequencing of the unit.
  always_ff @(posedge clk) begin
    if (rst) begin
      sq_go  <= 1'b0;
      sum_go <= 1'b0;
      run    <= 1'b0;
      done   <= 1'b0;
    end else begin
      sq_go  <= start;
      sum_go <= sq_go;
      done   <= run && (cnt == ITW'(1));
      if (sum_go) begin
        run <= 1'b1;
      end else if (run && cnt == ITW'(1)) begin
        run <= 1'b0;
      end
    end
  end

  // Operand and iteration registers.
  always_ff @(posedge clk) begin
    if (start) begin
      ux <= dx[C] ? (C+1)'(-dx) : (C+1)'(dx);
      uy <= dy[C] ? (C+1)'(-dy) : (C+1)'(dy);
    end
    if (sq_go) begin
      sqx <= ux * ux;
      sqy <= uy * uy;
    end
    if (sum_go) begin
      rad  <= RW'(SW'(sqx) + SW'(sqy)) << (2 * FRAC_BITS);
      rem  <= '0;
      root <= '0;
      cnt  <= ITW'(RB);
    end else if (run) begin
      rad  <= rad << 2;
      rem  <= rem_next;
      root <= root_next;
      cnt  <= cnt - ITW'(1);
    end
  end

  assign dist_len = (64'(root) > 64'(COST_MAX)) ? COST_MAX : 32'(root);

endmodule
`default_nettype wire

// File: rtl/anep_dp.sv
`default_nettype none
module anep_dp #(
  parameter int MAX_NODES  = anep_pkg::MAX_NODES_DEF,
  parameter int MAX_DEGREE = anep_pkg::MAX_DEGREE_DEF,
  parameter int COORD_BITS = anep_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = anep_pkg::FRAC_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic [anep_pkg::IN_TDATA_W-1:0]    s_tdata,
  input  wire logic [anep_pkg::IN_TUSER_W-1:0]    s_tuser,
  input  wire anep_pkg::cmd_t                     cmd,
  output anep_pkg::dp_stat_t                      stat,
  input  wire logic                               m_tready,
  output logic                                    m_tvalid,
  output logic [anep_pkg::OUT_TDATA_W-1:0]        m_tdata,
  output logic                                    m_tlast
);
  import anep_pkg::*;

  localparam int NW  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int CW  = $clog2(MAX_NODES + 1);
  localparam int DW  = $clog2(MAX_DEGREE + 1);
  localparam int EW  = $clog2(MAX_NODES * MAX_DEGREE);
  localparam int C   = COORD_BITS;
  localparam int NEW = 2 * C + 1;

  // Latched input item.
  op_t                  in_op;
  logic signed [C-1:0]  in_x, in_y;
  logic                 in_exit;
  logic [IDX_IN_W-1:0]  in_from, in_to;

  // Graph and search state.
  logic [CW-1:0]        node_count;
  logic                 any_exit;
  logic [MAX_NODES-1:0] cnt_vld, open_m, closed_m;

  logic [NEW-1:0]  node_mem [MAX_NODES];
  logic [NW-1:0]   nbr_mem  [MAX_NODES * MAX_DEGREE];
  logic [DW-1:0]   cnt_mem  [MAX_NODES];
  logic [31:0]     g_mem    [MAX_NODES];
  logic [31:0]     f_mem    [MAX_NODES];
  logic [NW-1:0]   par_mem  [MAX_NODES];

  logic [NEW-1:0]  node_rd;
  logic [NW-1:0]   nbr_rd, par_rd;
  logic [DW-1:0]   cnt_rd;
  logic            cnt_rd_vld;
  logic [31:0]     g_rd, f_rd;

  logic [CW-1:0]   i;
  logic [DW-1:0]   k, cur_cnt;
  logic [NW-1:0]   rd_idx, start_idx, best_idx, cur, nb;
  logic [31:0]     best_f, cur_g, nb_gold, tent, h_min;
  logic            best_found;
  logic signed [C-1:0] cur_x, cur_y, nb_x, nb_y;

  logic [15:0]     out_x, out_y;
  status_t         out_status;
  logic            out_last;

  // Read-side views and derived values.
  logic signed [C-1:0] rd_x, rd_y;
  logic                rd_exit;
  logic [DW-1:0]       cnt_cur;
  logic [NW-1:0]       from_idx, to_idx;
  logic [EW-1:0]       nbr_wa, nbr_ra;
  logic                node_re, g_re, cnt_re;
  logic [NW-1:0]       node_ra, g_ra, cnt_ra;
  logic                out_free, emit, dist_start, dist_done;
  logic [31:0]         dist_len;

  assign rd_x     = node_rd[C-1:0];
  assign rd_y     = node_rd[2*C-1:C];
  assign rd_exit  = node_rd[2*C];
  assign cnt_cur  = cnt_rd_vld ? cnt_rd : '0;
  assign from_idx = in_from[NW-1:0];
  assign to_idx   = in_to[NW-1:0];
  assign nbr_wa   = EW'(from_idx) * EW'(MAX_DEGREE) + EW'(cnt_cur);
  assign nbr_ra   = EW'(cur) * EW'(MAX_DEGREE) + EW'(k);
  assign out_free = !m_tvalid || m_tready;
  assign emit     = (cmd.op == CMD_ERR) || (cmd.op == CMD_PATH_OUT);
  assign dist_start = (cmd.op == CMD_NB_LD) || (cmd.op == CMD_H_CHK);

  // Read address selection for the node, cost and count stores.
  always_comb begin
    node_re = 1'b1;
    node_ra = i[NW-1:0];
    unique case (cmd.op)
      CMD_FIND_RD, CMD_H_RD: node_ra = i[NW-1:0];
      CMD_CUR_RD:            node_ra = best_idx;
      CMD_NB_CHK:            node_ra = nbr_rd;
      CMD_PATH_RD:           node_ra = cur;
      default:               node_re = 1'b0;
    endcase
    g_re   = (cmd.op == CMD_CUR_RD) || (cmd.op == CMD_NB_CHK);
    g_ra   = (cmd.op == CMD_CUR_RD) ? best_idx : nbr_rd;
    cnt_re = (cmd.op == CMD_CNT_RD) || (cmd.op == CMD_CUR_RD);
    cnt_ra = (cmd.op == CMD_CUR_RD) ? best_idx : from_idx;
  end

  // Node store.
  always_ff @(posedge clk) begin
    if (cmd.op == CMD_NODE_WR) begin
      node_mem[node_count[NW-1:0]] <= {in_exit, in_y, in_x};
    end
    if (node_re) begin
      node_rd <= node_mem[node_ra];
    end
  end

  // Neighbour lists.
  always_ff @(posedge clk) begin
    if (cmd.op == CMD_EDGE_WR) begin
      nbr_mem[nbr_wa] <= to_idx;
    end
    if (cmd.op == CMD_NB_RD) begin
      nbr_rd <= nbr_mem[nbr_ra];
    end
  end

  // Neighbour counts; an entry without its valid bit reads as zero.
  always_ff @(posedge clk) begin
    if (cmd.op == CMD_EDGE_WR) begin
      cnt_mem[from_idx] <= cnt_cur + DW'(1);
    end
    if (cnt_re) begin
      cnt_rd     <= cnt_mem[cnt_ra];
      cnt_rd_vld <= cnt_vld[cnt_ra];
    end
  end

  // Path cost store.
  always_ff @(posedge clk) begin
    if (cmd.op == CMD_INIT) begin
      g_mem[start_idx] <= '0;
    end else if (cmd.op == CMD_RELAX) begin
      g_mem[nb] <= tent;
    end
    if (g_re) begin
      g_rd <= g_mem[g_ra];
    end
  end

  // Estimated total cost store.
  always_ff @(posedge clk) begin
    if (cmd.op == CMD_INIT) begin
      f_mem[start_idx] <= '0;
    end else if (cmd.op == CMD_F_WR) begin
      f_mem[nb] <= sat_add(tent, h_min);
    end
    if (cmd.op == CMD_SEL_RD) begin
      f_rd <= f_mem[i[NW-1:0]];
    end
  end

  // Parent links.
  always_ff @(posedge clk) begin
    if (cmd.op == CMD_RELAX) begin
      par_mem[nb] <= cur;
    end
    if (cmd.op == CMD_PATH_RD) begin
      par_rd <= par_mem[cur];
    end
  end

  // Distance unit shared by step costs and the exit heuristic.
  anep_dist #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dist (
    .clk      (clk),
    .rst      (rst),
    .start    (dist_start),
    .ax       ((cmd.op == CMD_H_CHK) ? nb_x : cur_x),
    .ay       ((cmd.op == CMD_H_CHK) ? nb_y : cur_y),
    .bx       (rd_x),
    .by       (rd_y),
    .done     (dist_done),
    .dist_len (dist_len)
  );

  // Control state: table fill, valid bits, open and closed marks, output slot.
  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= '0;
      any_exit   <= 1'b0;
      cnt_vld    <= '0;
      open_m     <= '0;
      closed_m   <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      if (cmd.op == CMD_NODE_WR) begin
        node_count <= node_count + CW'(1);
        any_exit   <= any_exit | in_exit;
      end
      if (cmd.op == CMD_EDGE_WR) begin
        cnt_vld[from_idx] <= 1'b1;
      end
      if (cmd.op == CMD_INIT) begin
        open_m   <= MAX_NODES'(1) << start_idx;
        closed_m <= '0;
      end
      if (cmd.op == CMD_CUR_LD && !rd_exit) begin
        open_m[cur]   <= 1'b0;
        closed_m[cur] <= 1'b1;
      end
      if (cmd.op == CMD_RELAX) begin
        open_m[nb] <= 1'b1;
      end
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Working registers of the search and the result register.
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      CMD_ACCEPT: begin
        in_op   <= op_t'(s_tuser);
        in_x    <= C'(signed'(s_tdata[PX_LSB +: FIELD_W]));
        in_y    <= C'(signed'(s_tdata[PY_LSB +: FIELD_W]));
        in_exit <= s_tdata[EXIT_BIT];
        in_from <= s_tdata[FROM_LSB +: IDX_IN_W];
        in_to   <= s_tdata[TO_LSB +: IDX_IN_W];
      end
      CMD_IDX_CLR: begin
        i          <= '0;
        best_found <= 1'b0;
      end
      CMD_FIND_RD, CMD_SEL_RD, CMD_H_RD: begin
        rd_idx <= i[NW-1:0];
        i      <= i + CW'(1);
      end
      CMD_FIND_CHK: begin
        if (rd_x == in_x && rd_y == in_y) begin
          start_idx <= rd_idx;
        end
      end
      CMD_SEL_CHK: begin
        if (open_m[rd_idx] && (!best_found || f_rd < best_f)) begin
          best_idx   <= rd_idx;
          best_f     <= f_rd;
          best_found <= 1'b1;
        end
      end
      CMD_CUR_RD: begin
        cur <= best_idx;
      end
      CMD_CUR_LD: begin
        cur_x   <= rd_x;
        cur_y   <= rd_y;
        cur_g   <= g_rd;
        cur_cnt <= cnt_cur;
        k       <= '0;
      end
      CMD_NB_RD: begin
        k <= k + DW'(1);
      end
      CMD_NB_CHK: begin
        nb <= nbr_rd;
      end
      CMD_NB_LD: begin
        nb_x    <= rd_x;
        nb_y    <= rd_y;
        nb_gold <= g_rd;
      end
      CMD_TENT: begin
        tent <= sat_add(cur_g, dist_len);
      end
      CMD_RELAX: begin
        i     <= '0;
        h_min <= COST_MAX;
      end
      CMD_H_MIN: begin
        if (dist_len < h_min) begin
          h_min <= dist_len;
        end
      end
      CMD_ERR: begin
        out_x      <= '0;
        out_y      <= '0;
        out_status <= cmd.err;
        out_last   <= 1'b1;
      end
      CMD_PATH_OUT: begin
        out_x      <= 16'(rd_x);
        out_y      <= 16'(rd_y);
        out_status <= ST_PATH;
        out_last   <= (cur == start_idx);
        cur        <= par_rd;
      end
      default: begin
      end
    endcase
  end

  assign m_tdata = OUT_TDATA_W'({out_status, out_y, out_x});
  assign m_tlast = out_last;

  // Status toward the controller.
  always_comb begin
    stat.in_op      = in_op;
    stat.full       = (node_count == CW'(MAX_NODES));
    stat.edge_bad   = ({1'b0, in_from} >= 7'(node_count)) || ({1'b0, in_to} >= 7'(node_count));
    stat.cnt_full   = (cnt_cur >= DW'(MAX_DEGREE));
    stat.idx_end    = (i == node_count);
    stat.find_hit   = (rd_x == in_x) && (rd_y == in_y);
    stat.any_exit   = any_exit;
    stat.best_found = best_found;
    stat.cur_exit   = rd_exit;
    stat.k_end      = (k >= cur_cnt);
    stat.nb_skip    = closed_m[nbr_rd] || (CW'(nbr_rd) >= node_count);
    stat.dist_done  = dist_done;
    stat.relax_skip = open_m[nb] && (tent >= nb_gold);
    stat.h_exit     = rd_exit;
    stat.path_last  = (cur == start_idx);
    stat.out_free   = out_free;
  end

  // A node is never open and closed at once.
  assert property (@(posedge clk) disable iff (rst) (open_m & closed_m) == '0)
    else $error("node both open and closed");

  // The node table never fills past its depth.
  assert property (@(posedge clk) disable iff (rst) node_count <= CW'(MAX_NODES))
    else $error("node count beyond table depth");

  // A result is loaded only into a free output slot.
  assert property (@(posedge clk) disable iff (rst) emit |-> out_free)
    else $error("result loaded over a pending transfer");

  // A neighbour list never grows past its degree.
  assert property (@(posedge clk) disable iff (rst)
    (cmd.op == CMD_EDGE_WR) |-> (cnt_cur < DW'(MAX_DEGREE)))
    else $error("neighbour list overflow");

endmodule
`default_nettype wire

// File: rtl/anep_ctrl.sv
`default_nettype none
module anep_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire anep_pkg::dp_stat_t stat,
  output anep_pkg::cmd_t          cmd
);
  import anep_pkg::*;

  typedef enum logic [24:0] {
    S_IDLE      = 25'h0000001,
    S_DISPATCH  = 25'h0000002,
    S_NODE_WR   = 25'h0000004,
    S_CNT_RD    = 25'h0000008,
    S_EDGE_CHK  = 25'h0000010,
    S_ERR       = 25'h0000020,
    S_FIND_RD   = 25'h0000040,
    S_FIND_CHK  = 25'h0000080,
    S_INIT      = 25'h0000100,
    S_SEL_START = 25'h0000200,
    S_SEL_RD    = 25'h0000400,
    S_SEL_CHK   = 25'h0000800,
    S_CUR_RD    = 25'h0001000,
    S_CUR_LD    = 25'h0002000,
    S_NB_RD     = 25'h0004000,
    S_NB_CHK    = 25'h0008000,
    S_NB_LD     = 25'h0010000,
    S_D1_WAIT   = 25'h0020000,
    S_RELAX     = 25'h0040000,
    S_H_RD      = 25'h0080000,
    S_H_CHK     = 25'h0100000,
    S_H_WAIT    = 25'h0200000,
    S_F_WR      = 25'h0400000,
    S_PATH_RD   = 25'h0800000,
    S_PATH_OUT  = 25'h1000000
  } state_t;

  state_t  state, state_next;
  status_t err_code, err_code_next;

  // Next state and the datapath operation of this cycle.
  always_comb begin
    state_next    = state;
    err_code_next = err_code;
    cmd.op        = CMD_IDLE;
    cmd.err       = err_code;
    in_ready      = (state == S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = CMD_ACCEPT;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        cmd.op = CMD_IDX_CLR;
        unique case (stat.in_op)
          OP_NODE: begin
            if (stat.full) begin
              err_code_next = ST_FULL;
              state_next    = S_ERR;
            end else begin
              state_next = S_NODE_WR;
            end
          end
          OP_EDGE:   state_next = stat.edge_bad ? S_IDLE : S_CNT_RD;
          OP_SEARCH: state_next = S_FIND_RD;
          default:   state_next = S_IDLE;
        endcase
      end
      S_NODE_WR: begin
        cmd.op     = CMD_NODE_WR;
        state_next = S_IDLE;
      end
      S_CNT_RD: begin
        cmd.op     = CMD_CNT_RD;
        state_next = S_EDGE_CHK;
      end
      S_EDGE_CHK: begin
        if (stat.cnt_full) begin
          err_code_next = ST_FULL;
          state_next    = S_ERR;
        end else begin
          cmd.op     = CMD_EDGE_WR;
          state_next = S_IDLE;
        end
      end
      S_ERR: begin
        if (stat.out_free) begin
          cmd.op     = CMD_ERR;
          state_next = S_IDLE;
        end
      end
      S_FIND_RD: begin
        if (stat.idx_end) begin
          err_code_next = ST_NO_START;
          state_next    = S_ERR;
        end else begin
          cmd.op     = CMD_FIND_RD;
          state_next = S_FIND_CHK;
        end
      end
      S_FIND_CHK: begin
        cmd.op = CMD_FIND_CHK;
        if (!stat.find_hit) begin
          state_next = S_FIND_RD;
        end else if (stat.any_exit) begin
          state_next = S_INIT;
        end else begin
          err_code_next = ST_NO_EXIT;
          state_next    = S_ERR;
        end
      end
      S_INIT: begin
        cmd.op     = CMD_INIT;
        state_next = S_SEL_START;
      end
      S_SEL_START: begin
        cmd.op     = CMD_IDX_CLR;
        state_next = S_SEL_RD;
      end
      S_SEL_RD: begin
        if (stat.idx_end) begin
          state_next = S_CUR_RD;
        end else begin
          cmd.op     = CMD_SEL_RD;
          state_next = S_SEL_CHK;
        end
      end
      S_SEL_CHK: begin
        cmd.op     = CMD_SEL_CHK;
        state_next = S_SEL_RD;
      end
      S_CUR_RD: begin
        if (!stat.best_found) begin
          err_code_next = ST_NO_PATH;
          state_next    = S_ERR;
        end else begin
          cmd.op     = CMD_CUR_RD;
          state_next = S_CUR_LD;
        end
      end
      S_CUR_LD: begin
        cmd.op     = CMD_CUR_LD;
        state_next = stat.cur_exit ? S_PATH_RD : S_NB_RD;
      end
      S_NB_RD: begin
        if (stat.k_end) begin
          state_next = S_SEL_START;
        end else begin
          cmd.op     = CMD_NB_RD;
          state_next = S_NB_CHK;
        end
      end
      S_NB_CHK: begin
        if (stat.nb_skip) begin
          state_next = S_NB_RD;
        end else begin
          cmd.op     = CMD_NB_CHK;
          state_next = S_NB_LD;
        end
      end
      S_NB_LD: begin
        cmd.op     = CMD_NB_LD;
        state_next = S_D1_WAIT;
      end
      S_D1_WAIT: begin
        if (stat.dist_done) begin
          cmd.op     = CMD_TENT;
          state_next = S_RELAX;
        end
      end
      S_RELAX: begin
        if (stat.relax_skip) begin
          state_next = S_NB_RD;
        end else begin
          cmd.op     = CMD_RELAX;
          state_next = S_H_RD;
        end
      end
      S_H_RD: begin
        if (stat.idx_end) begin
          state_next = S_F_WR;
        end else begin
          cmd.op     = CMD_H_RD;
          state_next = S_H_CHK;
        end
      end
      S_H_CHK: begin
        if (stat.h_exit) begin
          cmd.op     = CMD_H_CHK;
          state_next = S_H_WAIT;
        end else begin
          state_next = S_H_RD;
        end
      end
      S_H_WAIT: begin
        if (stat.dist_done) begin
          cmd.op     = CMD_H_MIN;
          state_next = S_H_RD;
        end
      end
      S_F_WR: begin
        cmd.op     = CMD_F_WR;
        state_next = S_NB_RD;
      end
      S_PATH_RD: begin
        cmd.op     = CMD_PATH_RD;
        state_next = S_PATH_OUT;
      end
      S_PATH_OUT: begin
        if (stat.out_free) begin
          cmd.op     = CMD_PATH_OUT;
          state_next = stat.path_last ? S_IDLE : S_PATH_RD;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      err_code <= ST_PATH;
    end else begin
      state    <= state_next;
      err_code <= err_code_next;
    end
  end

endmodule
`default_nettype wire

// File: rtl/astar_nearest_exit_path_top.sv
`default_nettype none
// Nearest-exit path finder over a small directed graph. A node transfer (tuser 0) appends a
// point to the node table and may flag it as an exit; an edge transfer (tuser 1) appends a
// directed neighbour; a search transfer (tuser 2) runs A* from the first node whose point
// equals the given one and returns the path from the reached exit back to the start, one
// output transfer per node with tlast on the start, or a single error transfer. An error
// waits for a free output slot. A search runs as long as the graph demands: it scans the
// nodes to find the start, scans them again for each open-set selection, reads and skips
// closed or out-of-range neighbours, evaluates every other neighbour with one pass of the
// bit-serial square root unit, and, for every relaxed neighbour, sweeps the nodes for the
// nearest exit with one pass of the unit per exit. Path nodes are output one at a time and
// wait while the output is stalled. The single distance unit and the single read port of
// the node store serialise this work. No store needs a clearing pass after reset.
module astar_nearest_exit_path_top #(
  parameter int MAX_NODES  = anep_pkg::MAX_NODES_DEF,
  parameter int MAX_DEGREE = anep_pkg::MAX_DEGREE_DEF,
  parameter int COORD_BITS = anep_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = anep_pkg::FRAC_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // pos_x[15:0], pos_y[31:16], is_exit[32], from_index[38:33], to_index[44:39]
  input  wire logic [anep_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // op[1:0]
  input  wire logic [anep_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // out_x[15:0], out_y[31:16], status[34:32]
  output logic [anep_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
  output logic                                  m_axis_tlast
);
  import anep_pkg::*;

  cmd_t     cmd;
  dp_stat_t stat;

  // Sequencer.
  anep_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Stores, search registers and the distance unit.
  anep_dp #(
    .MAX_NODES  (MAX_NODES),
    .MAX_DEGREE (MAX_DEGREE),
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_axis_tdata),
    .s_tuser  (s_axis_tuser),
    .cmd      (cmd),
    .stat     (stat),
    .m_tready (m_axis_tready),
    .m_tvalid (m_axis_tvalid),
    .m_tdata  (m_axis_tdata),
    .m_tlast  (m_axis_tlast)
  );

endmodule
`default_nettype wire

// File: sim/tb_astar_nearest_exit_path_top.sv
`timescale 1ns / 1ps
module tb_astar_nearest_exit_path_top;
  import anep_pkg::*;

  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    status_t            st;
    bit                 last;
  } path_res_t;

  // Path predictor and store of expected path and error transfers.
  class path_scoreboard;
    logic signed [15:0] nx[64];
    logic signed [15:0] ny[64];
    bit                 ex[64];
    int                 node_cnt;
    bit [5:0]           nbr[64][8];
    int                 nbr_cnt[64];
    path_res_t          pending_q[$];
    int                 errors;

    function new();
      node_cnt = 0;
      errors = 0;
      foreach (nbr_cnt[i]) nbr_cnt[i] = 0;
    endfunction

    // Floor of the Euclidean distance with 8 fraction bits.
    function bit [31:0] step_len(int a, int b);
      longint   dx, dy;
      bit [63:0] v, r, t;
      dx = longint'(nx[a]) - longint'(nx[b]);
      dy = longint'(ny[a]) - longint'(ny[b]);
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      v = (dx * dx + dy * dy) << 16;
      r = 0;
      for (int b2 = 31; b2 >= 0; b2--) begin
        t = r | (64'd1 << b2);
        if (t * t <= v) r = t;
      end
      return r[31:0];
    endfunction

    function bit [31:0] sat_sum(bit [31:0] a, bit [31:0] b);
      bit [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function bit [31:0] exit_dist(int n);
      bit [31:0] best, d;
      best = 32'hFFFF_FFFF;
      for (int i = 0; i < node_cnt; i++)
        if (ex[i]) begin
          d = step_len(n, i);
          if (d < best) best = d;
        end
      return best;
    endfunction

    function void push_res(logic signed [15:0] x, logic signed [15:0] y, status_t st,
                           bit last);
      path_res_t r;
      r.x = x;
      r.y = y;
      r.st = st;
      r.last = last;
      pending_q = {pending_q, r};
    endfunction

    function void find_path(logic signed [15:0] sx, logic signed [15:0] sy);
      int        start, cur, nb, n, p;
      bit        any_exit;
      bit        opn[64];
      bit        cls[64];
      bit [31:0] g[64];
      bit [31:0] f[64];
      int        par[64];
      bit [31:0] tent;
      start = -1;
      any_exit = 0;
      for (int i = 0; i < node_cnt; i++)
        if (start < 0 && nx[i] == sx && ny[i] == sy) start = i;
      if (start < 0) begin
        push_res(0, 0, ST_NO_START, 1);
        return;
      end
      for (int i = 0; i < node_cnt; i++) if (ex[i]) any_exit = 1;
      if (!any_exit) begin
        push_res(0, 0, ST_NO_EXIT, 1);
        return;
      end
      foreach (opn[i]) begin
        opn[i] = 0;
        cls[i] = 0;
        par[i] = -1;
        g[i] = 0;
        f[i] = 0;
      end
      opn[start] = 1;
      forever begin
        cur = -1;
        for (int i = 0; i < node_cnt; i++)
          if (opn[i] && (cur < 0 || f[i] < f[cur])) cur = i;
        if (cur < 0) begin
          push_res(0, 0, ST_NO_PATH, 1);
          return;
        end
        if (ex[cur]) break;
        opn[cur] = 0;
        cls[cur] = 1;
        for (int k = 0; k < nbr_cnt[cur]; k++) begin
          nb = int'(nbr[cur][k]);
          if (nb >= node_cnt || cls[nb]) continue;
          tent = sat_sum(g[cur], step_len(cur, nb));
          if (!opn[nb]) opn[nb] = 1;
          else if (tent >= g[nb]) continue;
          par[nb] = cur;
          g[nb] = tent;
          f[nb] = sat_sum(tent, exit_dist(nb));
        end
      end
      // Walk back from the reached exit to the start.
      n = 0;
      forever begin
        p = par[cur];
        push_res(nx[cur], ny[cur], ST_PATH, (p < 0) || (n == 63));
        n++;
        if (p < 0 || n == 64) break;
        cur = p;
      end
    endfunction

    // Note an accepted input transfer and work out its results.
    function void note_input(op_t op, logic [IN_TDATA_W-1:0] d);
      int from_i, to_i;
      from_i = int'(d[FROM_LSB +: IDX_IN_W]);
      to_i = int'(d[TO_LSB +: IDX_IN_W]);
      case (op)
        OP_NODE: begin
          if (node_cnt >= 64) push_res(0, 0, ST_FULL, 1);
          else begin
            nx[node_cnt] = d[PX_LSB +: 16];
            ny[node_cnt] = d[PY_LSB +: 16];
            ex[node_cnt] = d[EXIT_BIT];
            node_cnt++;
          end
        end
        OP_EDGE: begin
          if (from_i < node_cnt && to_i < node_cnt) begin
            if (nbr_cnt[from_i] >= 8) push_res(0, 0, ST_FULL, 1);
            else begin
              nbr[from_i][nbr_cnt[from_i]] = 6'(to_i);
              nbr_cnt[from_i]++;
            end
          end
        end
        OP_SEARCH: find_path(d[PX_LSB +: 16], d[PY_LSB +: 16]);
        default: ;
      endcase
    endfunction

    // Check one output transfer against the oldest expectation.
    function void check(logic [OUT_TDATA_W-1:0] d, logic last);
      path_res_t r;
      if (pending_q.size() == 0) begin
        $error("unexpected output transfer: tdata %h tlast %b", d, last);
        errors++;
        return;
      end
      r = pending_q.pop_front();
      if (d[15:0] !== r.x) begin
        $error("out_x: expected %0d, actual %0d", r.x, $signed(d[15:0]));
        errors++;
      end
      if (d[31:16] !== r.y) begin
        $error("out_y: expected %0d, actual %0d", r.y, $signed(d[31:16]));
        errors++;
      end
      if (d[34:32] !== r.st) begin
        $error("status: expected %0d, actual %0d", r.st, d[34:32]);
        errors++;
      end
      if (last !== r.last) begin
        $error("last: expected %0b, actual %0b", r.last, last);
        errors++;
      end
    endfunction
  endclass

  logic                   clk;
  logic                   rst;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic [IN_TUSER_W-1:0]  s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tlast;

  path_scoreboard sb;
  int             send_idle_pct;
  int             recv_stall_pct;

  astar_nearest_exit_path_top u_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  // Clock.
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Receiver side: random stalls and checking of each output transfer.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check(m_axis_tdata, m_axis_tlast);
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Drive one input transfer and wait until it is accepted.
  task automatic send_item(op_t op, logic signed [15:0] x, logic signed [15:0] y, bit ex,
                           int from_i, int to_i);
    logic [IN_TDATA_W-1:0] d;
    d = '0;
    d[PX_LSB +: 16] = x;
    d[PY_LSB +: 16] = y;
    d[EXIT_BIT] = ex;
    d[FROM_LSB +: IDX_IN_W] = from_i[5:0];
    d[TO_LSB +: IDX_IN_W] = to_i[5:0];
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= d;
    s_axis_tuser <= op;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_input(op, d);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [15:0] rand_coord();
    case ($urandom_range(3))
      0: return 16'($urandom);
      1: return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
      default: return 16'($signed($urandom_range(80)) - 40);
    endcase
  endfunction

  // Random item mix: mostly graph building and searches from known nodes.
  task automatic send_random();
    int                 r, k;
    logic signed [15:0] x, y;
    r = $urandom_range(99);
    if (r < 25) begin
      send_item(OP_NODE, rand_coord(), rand_coord(), ($urandom_range(99) < 15), 0, 0);
    end else if (r < 70) begin
      k = sb.node_cnt + 2;
      if (k > 63) k = 63;
      if ($urandom_range(9) == 0) k = 63;
      send_item(OP_EDGE, 16'($urandom), 16'($urandom), 1'($urandom_range(1)),
                $urandom_range(k), $urandom_range(k));
    end else if (r < 95) begin
      if (sb.node_cnt > 0 && $urandom_range(99) < 80) begin
        k = $urandom_range(sb.node_cnt - 1);
        x = sb.nx[k];
        y = sb.ny[k];
      end else begin
        x = rand_coord();
        y = rand_coord();
      end
      send_item(OP_SEARCH, x, y, 1'($urandom_range(1)), $urandom, $urandom);
    end else begin
      send_item(OP_NONE, 16'($urandom), 16'($urandom), 1'($urandom_range(1)),
                $urandom, $urandom);
    end
  endtask

  task automatic run_phase(int count, int idle_pct, int stall_pct);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) send_random();
  endtask

  // Stimulus.
  initial begin
    sb = new();
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = OP_NODE;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: error results, trivial paths, extremes and a full neighbour list.
    send_item(OP_SEARCH, 0, 0, 0, 0, 0);
    send_item(OP_NODE, 0, 0, 0, 0, 0);
    send_item(OP_SEARCH, 0, 0, 0, 0, 0);
    send_item(OP_NODE, 3, 4, 1, 0, 0);
    send_item(OP_SEARCH, 0, 0, 0, 0, 0);
    send_item(OP_EDGE, 0, 0, 0, 0, 1);
    send_item(OP_SEARCH, 0, 0, 0, 0, 0);
    send_item(OP_SEARCH, 3, 4, 0, 0, 0);
    send_item(OP_EDGE, 0, 0, 0, 5, 0);
    send_item(OP_NONE, -1, -1, 1, 63, 63);
    send_item(OP_NODE, 16'sh7FFF, 16'sh8000, 0, 0, 0);
    send_item(OP_NODE, 16'sh8000, 16'sh7FFF, 1, 0, 0);
    send_item(OP_EDGE, 0, 0, 0, 0, 2);
    send_item(OP_EDGE, 0, 0, 0, 2, 3);
    send_item(OP_EDGE, 0, 0, 0, 0, 0);
    send_item(OP_EDGE, 0, 0, 0, 0, 1);
    send_item(OP_EDGE, 0, 0, 0, 0, 3);
    send_item(OP_EDGE, 0, 0, 0, 0, 2);
    send_item(OP_EDGE, 0, 0, 0, 0, 1);
    send_item(OP_EDGE, 0, 0, 0, 0, 3);
    send_item(OP_EDGE, 0, 0, 0, 0, 3);
    send_item(OP_SEARCH, 0, 0, 0, 0, 0);
    send_item(OP_SEARCH, 16'sh7FFF, 16'sh8000, 0, 0, 0);

    // Random: idle and stall phases, with one full drain in the middle and one at the end.
    run_phase(75, 0, 0);
    run_phase(40, 57, 0);
    wait_drained();
    run_phase(35, 57, 0);
    run_phase(75, 0, 57);
    run_phase(75, 36, 36);
    wait_drained();
    repeat (300) @(posedge clk);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("astar_nearest_exit_path_top verification clean");
    end else begin
      $display("astar_nearest_exit_path_top verification failed");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #500ms;
    $display("astar_nearest_exit_path_top verification failed");
    $finish;
  end

endmodule
